>>> rtl/core/smmd_pkg.sv
// Shared types, constants and helpers for the stencil min/max deviation block.
package smmd_pkg;

   localparam int GRID_MAX_DEF   = 64;
   localparam int RADIAL_MAX_DEF = 128;

   localparam int VALUE_W    = 24;
   localparam int PLUS_W     = VALUE_W - 1;
   localparam int GRID_W     = 7;
   localparam int RADIAL_W   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [GRID_W-1:0]   GRID_RESET   = GRID_W'(64);
   localparam logic [RADIAL_W-1:0] RADIAL_RESET = RADIAL_W'(128);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_N   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL_N = CSR_IDX_W'(1);

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic [RADIAL_W-1:0] k;
      logic [GRID_W-1:0]   j;
      logic [GRID_W-1:0]   i;
   } pos_type;

   localparam pos_type POS_SECOND = '{k: RADIAL_W'(0), j: GRID_W'(0), i: GRID_W'(1)};

   typedef struct packed {
      logic [GRID_W-1:0]   grid;
      logic [RADIAL_W-1:0] radial;
   } cfg_type;

   typedef struct packed {
      value_type hi;
      value_type lo;
   } plane_entry_type;

   typedef struct packed {
      value_type up;
      value_type mid;
      value_type below;
   } row_entry_type;

   typedef struct packed {
      value_type up;
      value_type mid;
      value_type down;
      value_type below;
   } column_type;

   typedef struct packed {
      value_type center;
      value_type up;
      value_type down;
      value_type left;
      value_type right;
      value_type below;
      pos_type   pos;
      logic      emit;
      logic      last;
   } stencil_type;

   function automatic pos_type pos_next(input pos_type p, input cfg_type c);
      pos_type r;
      r = p;
      if ({1'b0, p.i} >= ({1'b0, c.grid} + 8'd1)) begin
         r.i = '0;
         if ({1'b0, p.j} >= ({1'b0, c.grid} + 8'd1)) begin
            r.j = '0;
            if ({1'b0, p.k} >= ({1'b0, c.radial} + 9'd1)) begin
               r.k = '0;
            end else begin
               r.k = p.k + 1'b1;
            end
         end else begin
            r.j = p.j + 1'b1;
         end
      end else begin
         r.i = p.i + 1'b1;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/smmd_channels.sv
// Handshake channel interfaces for the request, response and register write ports.
interface smmd_req_if;
   import smmd_pkg::*;
   logic      valid;
   logic      ready;
   value_type sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface smmd_rsp_if;
   import smmd_pkg::*;
   logic                valid;
   logic                ready;
   logic [PLUS_W-1:0]   delta_plus;
   value_type           delta_minus;
   logic [GRID_W-1:0]   cell_i;
   logic [GRID_W-1:0]   cell_j;
   logic [RADIAL_W-1:0] cell_k;
   logic                last_of_face;
   modport source (output valid, output delta_plus, output delta_minus, output cell_i,
                   output cell_j, output cell_k, output last_of_face, input ready);
   modport sink (input valid, input delta_plus, input delta_minus, input cell_i,
                 input cell_j, input cell_k, input last_of_face, output ready);
endinterface

interface smmd_csr_if;
   import smmd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/smmd_planes.sv
// Plane and row memories, raster position tracking and the stencil window.
module smmd_planes #(
   parameter int MAX_GRID = smmd_pkg::GRID_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  smmd_pkg::cfg_type    cfg,
   input  logic                 restart,
   input  logic                 take,
   input  smmd_pkg::value_type  sample,
   output smmd_pkg::stencil_type stencil
);
   import smmd_pkg::*;

   localparam int ROW_LEN   = MAX_GRID + 2;
   localparam int PLANE_LEN = ROW_LEN * ROW_LEN;
   localparam int PLANE_AW  = $clog2(PLANE_LEN);
   localparam int ROW_AW    = $clog2(ROW_LEN);

   plane_entry_type plane_mem_ff [PLANE_LEN];
   row_entry_type   row_mem_ff [ROW_LEN];
   plane_entry_type plane_rd_ff;
   row_entry_type   row_rd_ff;
   plane_entry_type plane_wdata;
   row_entry_type   row_wdata;
   column_type      col_ff;
   column_type      col_in;
   value_type       left_ff;
   pos_type         cur_ff;
   pos_type         cur_in;
   pos_type         nxt_ff;
   pos_type         nxt_in;
   pos_type         fetch_pos;
   logic [GRID_W-1:0]   fetch_row;
   logic [PLANE_AW-1:0] plane_raddr;
   logic [PLANE_AW-1:0] plane_waddr;
   logic [ROW_AW-1:0]   row_raddr;
   logic [ROW_AW-1:0]   row_waddr;

   always_comb begin
      fetch_pos = pos_next(nxt_ff, cfg);
      if ({1'b0, fetch_pos.j} == ({1'b0, cfg.grid} + 8'd1)) begin
         fetch_row = '0;
      end else begin
         fetch_row = fetch_pos.j + 1'b1;
      end
      plane_raddr = PLANE_AW'(int'(fetch_row) * ROW_LEN + int'(fetch_pos.i));
      plane_waddr = PLANE_AW'(int'(cur_ff.j) * ROW_LEN + int'(cur_ff.i));
      row_raddr   = ROW_AW'(fetch_pos.i);
      row_waddr   = ROW_AW'(nxt_ff.i);
      plane_wdata = '{hi: sample, lo: col_ff.mid};
      row_wdata   = '{up: row_rd_ff.mid, mid: plane_rd_ff.hi, below: plane_rd_ff.lo};
      col_in      = '{up: row_rd_ff.up, mid: row_rd_ff.mid, down: plane_rd_ff.hi,
                      below: row_rd_ff.below};
   end

   always_comb begin
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      if (restart) begin
         cur_in = '0;
         nxt_in = POS_SECOND;
      end else if (take) begin
         cur_in = nxt_ff;
         nxt_in = fetch_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         nxt_ff <= POS_SECOND;
      end else begin
         cur_ff <= cur_in;
         nxt_ff <= nxt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         plane_mem_ff[plane_waddr] <= plane_wdata;
         plane_rd_ff <= plane_mem_ff[plane_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         row_mem_ff[row_waddr] <= row_wdata;
         row_rd_ff <= row_mem_ff[row_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         col_ff  <= col_in;
         left_ff <= col_ff.mid;
      end
   end

   always_comb begin
      stencil.center = col_ff.mid;
      stencil.up     = col_ff.up;
      stencil.down   = col_ff.down;
      stencil.below  = col_ff.below;
      stencil.left   = left_ff;
      stencil.right  = row_rd_ff.mid;
      stencil.pos    = cur_ff;
      stencil.emit   = (cur_ff.k >= RADIAL_W'(2)) && (cur_ff.i != '0) && (cur_ff.i <= cfg.grid)
                       && (cur_ff.j != '0) && (cur_ff.j <= cfg.grid);
      stencil.last   = ({1'b0, cur_ff.k} == ({1'b0, cfg.radial} + 9'd1))
                       && (cur_ff.i == cfg.grid) && (cur_ff.j == cfg.grid);
   end

endmodule

>>> rtl/core/stencil_min_max_deviation.sv
// Top level: seven-point stencil min/max deviation over one streamed volume face.
//
// req_ch takes one Q12.12 sample per request in raster order with halo
// (i fastest, then j, then k). Each request whose position completes an
// interior neighborhood yields one response on rsp_ch: half of max minus
// center, half of min minus center, the center coordinates and a flag on
// the final interior cell of the face. Other requests yield nothing.
// csr_ch writes grid_n (index 0) or radial_n (index 1); any write restarts
// the face at position zero. csr_ch is always ready.
// Throughput: one request per cycle while rsp_ch keeps up. Two planes live
// in one plane memory (two samples per entry) and a row memory carries two
// rows of the previous plane; each takes one read and one write per request.
// A result passes through the s1 stage and then the response register before
// it is offered on rsp_ch.
// When rsp_ch stalls, the held response plus one in the pipeline stage may
// wait; req_ch.ready drops only when both are full.
// Reset clears the position and sets grid_n to 64 and radial_n to 128. The
// memories are not cleared: the raster order writes every entry before use.
module stencil_min_max_deviation #(
   parameter int MAX_GRID   = smmd_pkg::GRID_MAX_DEF,
   parameter int MAX_RADIAL = smmd_pkg::RADIAL_MAX_DEF
) (
   input logic         clock,
   input logic         reset,
   smmd_req_if.sink    req_ch,
   smmd_rsp_if.source  rsp_ch,
   smmd_csr_if.sink    csr_ch
);
   import smmd_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   stencil_type stencil;
   logic        take;
   logic        restart;
   logic        adv_out;
   logic        adv_s1;
   value_type   nbr [7];
   value_type   hi;
   value_type   lo;

   logic        s1_valid_ff;
   value_type   s1_hi_ff;
   value_type   s1_lo_ff;
   value_type   s1_center_ff;
   pos_type     s1_pos_ff;
   logic        s1_last_ff;

   logic signed [VALUE_W:0] diff_hi;
   logic signed [VALUE_W:0] diff_lo;

   logic                rsp_valid_ff;
   logic [PLUS_W-1:0]   rsp_plus_ff;
   value_type           rsp_minus_ff;
   logic [GRID_W-1:0]   rsp_i_ff;
   logic [GRID_W-1:0]   rsp_j_ff;
   logic [RADIAL_W-1:0] rsp_k_ff;
   logic                rsp_last_ff;

   function automatic logic [GRID_W-1:0] clip_grid(input logic [GRID_W-1:0] v);
      logic [GRID_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = GRID_W'(1);
      end else if (int'(v) > MAX_GRID) begin
         r = GRID_W'(MAX_GRID);
      end
      return r;
   endfunction

   function automatic logic [RADIAL_W-1:0] clip_radial(input logic [RADIAL_W-1:0] v);
      logic [RADIAL_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = RADIAL_W'(1);
      end else if (int'(v) > MAX_RADIAL) begin
         r = RADIAL_W'(MAX_RADIAL);
      end
      return r;
   endfunction

   assign csr_ch.ready = 1'b1;
   assign restart      = csr_ch.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_GRID_N:   cfg_in.grid   = clip_grid(csr_ch.data[GRID_W-1:0]);
            CSR_RADIAL_N: cfg_in.radial = clip_radial(csr_ch.data[RADIAL_W-1:0]);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid   <= clip_grid(GRID_RESET);
         cfg_ff.radial <= clip_radial(RADIAL_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign adv_out      = !rsp_valid_ff || rsp_ch.ready;
   assign adv_s1       = !s1_valid_ff || adv_out;
   assign req_ch.ready = adv_s1;
   assign take         = req_ch.valid && adv_s1;

   smmd_planes #(
      .MAX_GRID (MAX_GRID)
   ) u_planes (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .restart (restart),
      .take    (take),
      .sample  (req_ch.sample_value),
      .stencil (stencil)
   );

   always_comb begin
      nbr[0] = stencil.center;
      nbr[1] = req_ch.sample_value;
      nbr[2] = stencil.below;
      nbr[3] = stencil.left;
      nbr[4] = stencil.right;
      nbr[5] = stencil.up;
      nbr[6] = stencil.down;
      hi = nbr[0];
      lo = nbr[0];
      for (int idx = 1; idx < 7; idx++) begin
         if (nbr[idx] > hi) hi = nbr[idx];
         if (nbr[idx] < lo) lo = nbr[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv_s1) begin
         s1_valid_ff <= take && stencil.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s1) begin
         s1_hi_ff     <= hi;
         s1_lo_ff     <= lo;
         s1_center_ff <= stencil.center;
         s1_pos_ff    <= stencil.pos;
         s1_last_ff   <= stencil.last;
      end
   end

   always_comb begin
      diff_hi = {s1_hi_ff[VALUE_W-1], s1_hi_ff} - {s1_center_ff[VALUE_W-1], s1_center_ff};
      diff_lo = {s1_lo_ff[VALUE_W-1], s1_lo_ff} - {s1_center_ff[VALUE_W-1], s1_center_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_plus_ff  <= diff_hi[VALUE_W-1:1];
         rsp_minus_ff <= diff_lo[VALUE_W:1];
         rsp_i_ff     <= s1_pos_ff.i;
         rsp_j_ff     <= s1_pos_ff.j;
         rsp_k_ff     <= s1_pos_ff.k - RADIAL_W'(1);
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.delta_plus   = rsp_plus_ff;
   assign rsp_ch.delta_minus  = rsp_minus_ff;
   assign rsp_ch.cell_i       = rsp_i_ff;
   assign rsp_ch.cell_j       = rsp_j_ff;
   assign rsp_ch.cell_k       = rsp_k_ff;
   assign rsp_ch.last_of_face = rsp_last_ff;

   a_extremes_bracket_center: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_hi_ff >= s1_center_ff) && (s1_center_ff >= s1_lo_ff))
      else $error("neighborhood extremes do not bracket the center");

   a_minus_not_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_minus_ff[VALUE_W-1] || (rsp_minus_ff == '0)))
      else $error("delta_minus is positive");

   a_full_pipe_blocks_request: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv_out) |-> !req_ch.ready)
      else $error("request taken while both result stages are full");

   a_last_on_diagonal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_i_ff == rsp_j_ff))
      else $error("last_of_face flagged off the final cell");

endmodule

>>> tb/sv/testbench.sv
// Testbench for the seven-point stencil min/max deviation block: random streams checked against an in-bench model.
module testbench;
   import smmd_pkg::*;

   localparam int ROW_SPAN     = GRID_MAX_DEF + 2;
   localparam int PLANE_SPAN   = ROW_SPAN * ROW_SPAN;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SQUEEZE_LEN  = 300;
   localparam int RANDOM_ITEMS = 450;

   localparam value_type SAMPLE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
   localparam value_type SAMPLE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};

   typedef struct packed {
      logic [PLUS_W-1:0]   delta_plus;
      value_type           delta_minus;
      logic [GRID_W-1:0]   cell_i;
      logic [GRID_W-1:0]   cell_j;
      logic [RADIAL_W-1:0] cell_k;
      logic                last_of_face;
   } deviation_type;

   logic clock;
   logic reset;

   smmd_req_if req_ch ();
   smmd_rsp_if rsp_ch ();
   smmd_csr_if csr_ch ();

   stencil_min_max_deviation dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   value_type           sample_backlog[$];
   deviation_type       pending_deviations[$];
   value_type           plane_mem [0:2*PLANE_SPAN-1];
   logic [GRID_W-1:0]   grid_reg;
   logic [RADIAL_W-1:0] radial_reg;
   int                  pos_i, pos_j, pos_k;

   int   samples_queued = 0;
   int   samples_taken  = 0;
   int   csr_writes     = 0;
   int   error_count    = 0;
   int   quiet_cycles   = 0;
   int   idle_odds      = 0;
   int   send_gap       = 0;
   int   rsp_stall      = 0;
   bit   req_took       = 1'b0;
   bit   squeeze_window = 1'b0;
   bit   squeezed       = 1'b0;

   function automatic int eff_grid();
      if (grid_reg == 0) return 1;
      if (grid_reg > GRID_MAX_DEF) return GRID_MAX_DEF;
      return int'(grid_reg);
   endfunction

   function automatic int eff_radial();
      if (radial_reg == 0) return 1;
      if (radial_reg > RADIAL_MAX_DEF) return RADIAL_MAX_DEF;
      return int'(radial_reg);
   endfunction

   function automatic int slot(int k, int i, int j);
      return (k % 2) * PLANE_SPAN + j * ROW_SPAN + i;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_GRID_N) begin
         grid_reg = val[GRID_W-1:0];
      end else if (idx == CSR_RADIAL_N) begin
         radial_reg = val[RADIAL_W-1:0];
      end
      pos_i = 0;
      pos_j = 0;
      pos_k = 0;
   endfunction

   function automatic void predict_deviation(value_type s);
      int            n, nr, c, hi, lo;
      int            nb[6];
      deviation_type d;
      n  = eff_grid();
      nr = eff_radial();
      if (pos_k >= 2 && pos_i >= 1 && pos_i <= n && pos_j >= 1 && pos_j <= n) begin
         c     = plane_mem[slot(pos_k - 1, pos_i, pos_j)];
         nb[0] = s;
         nb[1] = plane_mem[slot(pos_k - 2, pos_i, pos_j)];
         nb[2] = plane_mem[slot(pos_k - 1, pos_i + 1, pos_j)];
         nb[3] = plane_mem[slot(pos_k - 1, pos_i - 1, pos_j)];
         nb[4] = plane_mem[slot(pos_k - 1, pos_i, pos_j + 1)];
         nb[5] = plane_mem[slot(pos_k - 1, pos_i, pos_j - 1)];
         hi = c;
         lo = c;
         foreach (nb[m]) begin
            if (nb[m] > hi) hi = nb[m];
            if (nb[m] < lo) lo = nb[m];
         end
         d.delta_plus   = PLUS_W'((hi - c) >>> 1);
         d.delta_minus  = VALUE_W'((lo - c) >>> 1);
         d.cell_i       = GRID_W'(pos_i);
         d.cell_j       = GRID_W'(pos_j);
         d.cell_k       = RADIAL_W'(pos_k - 1);
         d.last_of_face = (pos_k == nr + 1 && pos_i == n && pos_j == n);
         pending_deviations.push_back(d);
      end
      plane_mem[slot(pos_k, pos_i, pos_j)] = s;
      if (pos_i >= n + 1) begin
         pos_i = 0;
         if (pos_j >= n + 1) begin
            pos_j = 0;
            pos_k = (pos_k >= nr + 1) ? 0 : pos_k + 1;
         end else begin
            pos_j++;
         end
      end else begin
         pos_i++;
      end
   endfunction

   function automatic value_type pick_sample();
      case ($urandom_range(15, 0))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         3: return '1;
         default: return value_type'($urandom);
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // accept side: check responses, track register writes, predict on requests
   always @(posedge clock) begin
      deviation_type want, got;
      bit            moved;
      req_took = 1'b0;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            got = '{rsp_ch.delta_plus, rsp_ch.delta_minus, rsp_ch.cell_i, rsp_ch.cell_j,
                    rsp_ch.cell_k, rsp_ch.last_of_face};
            if (pending_deviations.size() == 0) begin
               error_count++;
               $display("%0t unexpected response: dp=%0d dm=%0d i=%0d j=%0d k=%0d last=%0b",
                        $time, got.delta_plus, $signed(got.delta_minus), got.cell_i,
                        got.cell_j, got.cell_k, got.last_of_face);
            end else begin
               want = pending_deviations.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display({"%0t mismatch: expected dp=%0d dm=%0d i=%0d j=%0d k=%0d last=%0b,",
                            " actual dp=%0d dm=%0d i=%0d j=%0d k=%0d last=%0b"},
                           $time, want.delta_plus, $signed(want.delta_minus), want.cell_i,
                           want.cell_j, want.cell_k, want.last_of_face,
                           got.delta_plus, $signed(got.delta_minus), got.cell_i,
                           got.cell_j, got.cell_k, got.last_of_face);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            moved = 1'b1;
            apply_csr(csr_ch.index, csr_ch.data);
            csr_writes++;
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            predict_deviation(req_ch.sample_value);
            samples_taken++;
            req_took = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // request driver: hold until taken, then advance or idle
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_took)) begin
         if (send_gap != 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
            send_gap = $urandom_range(11, 0);
            req_ch.valid <= 1'b0;
         end else if (sample_backlog.size() != 0) begin
            req_ch.valid        <= 1'b1;
            req_ch.sample_value <= sample_backlog.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response side stalls
   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall--;
      end else if (squeeze_window && !squeezed && rsp_ch.valid) begin
         squeezed  = 1'b1;
         rsp_stall = SQUEEZE_LEN;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
         rsp_stall = $urandom_range(12, 1);
      end
      rsp_ch.ready <= (rsp_stall == 0);
   end

   initial begin
      do @(negedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      int seen;
      seen = csr_writes;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(negedge clock); while (csr_writes == seen);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (samples_taken != samples_queued || pending_deviations.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_size(logic [CSR_DATA_W-1:0] g, logic [CSR_DATA_W-1:0] r);
      wait_drained();
      if ($urandom_range(1, 0) == 0) begin
         write_reg(CSR_GRID_N, g);
         write_reg(CSR_RADIAL_N, r);
      end else begin
         write_reg(CSR_RADIAL_N, r);
         write_reg(CSR_GRID_N, g);
      end
      if ($urandom_range(5, 0) == 0)
         write_reg(CSR_IDX_W'($urandom_range(15, 2)), CSR_DATA_W'($urandom));
   endtask

   task automatic push_sample(value_type v);
      sample_backlog.push_back(v);
      samples_queued++;
   endtask

   task automatic push_random(int count);
      repeat (count) push_sample(pick_sample());
   endtask

   function automatic int face_span();
      return (eff_grid() + 2) * (eff_grid() + 2) * (eff_radial() + 2);
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] g, r;
      int                    span, count, random_items;
      req_ch.valid        = 1'b0;
      req_ch.sample_value = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      grid_reg            = GRID_RESET;
      radial_reg          = RADIAL_RESET;
      pos_i               = 0;
      pos_j               = 0;
      pos_k               = 0;
      random_items        = 0;
      reset               = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // reset sizes: the first rows of the first plane, no response yet
      idle_odds = 5;
      push_random(2 * ROW_SPAN);

      // grid of zero taken as one; opposite extremes on the two centers
      set_size(8'h80, 8'h02);
      for (int p = 0; p < 36; p++) begin
         if (p == 13) push_sample(SAMPLE_MIN);
         else if (p == 22) push_sample(SAMPLE_MAX);
         else push_sample((p % 2) ? '1 : '0);
      end

      // small face; hold the response side off once
      set_size(8'd4, 8'd3);
      idle_odds      = 6;
      squeeze_window = 1'b1;
      push_random(face_span());
      wait_drained();
      squeeze_window = 1'b0;

      // grid and radial beyond range clipped
      set_size(8'hFF, 8'hFF);
      push_random(3 * ROW_SPAN);

      while (random_items < RANDOM_ITEMS) begin
         g = ($urandom_range(3, 0) != 0) ? CSR_DATA_W'($urandom_range(4, 1))
                                         : CSR_DATA_W'($urandom_range(255, 0));
         r = ($urandom_range(3, 0) != 0) ? CSR_DATA_W'($urandom_range(4, 1))
                                         : CSR_DATA_W'($urandom_range(255, 0));
         set_size(g, r);
         idle_odds = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 3);
         span = face_span();
         if (span <= 220) begin
            count = span * $urandom_range(2, 1);
            if ($urandom_range(1, 0) == 0) count += $urandom_range(span - 1, 0);
         end else begin
            count = $urandom_range(200, 50);
         end
         push_random(count);
         random_items += count;
      end

      set_size(8'd3, 8'd2);
      idle_odds = 0;
      push_random(2 * face_span());
      wait_drained();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
